// ===== hdl/type1_charstring_encrypt_encoder_macros.svh =====
`ifndef TYPE1_CHARSTRING_ENCRYPT_ENCODER_MACROS_SVH
`define TYPE1_CHARSTRING_ENCRYPT_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TCE_ASSERT_NOW(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("tce assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TCE_ASSERT_NEXT(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("tce assertion failed");

`endif

// ===== hdl/tce_pkg.sv =====
`default_nettype none

package tce_pkg;

	localparam logic [15:0] CIPHER_MUL  = 16'd52845;
	localparam logic [15:0] CIPHER_ADD  = 16'd22719;
	localparam logic [15:0] CS_KEY_INIT = 16'd4330;
	localparam logic [15:0] EX_KEY_INIT = 16'd55665;
	localparam logic [3:0]  LEN_IV_INIT = 4'd4;
	localparam logic [3:0]  EX_LEAD_LEN = 4'd4;
	localparam int          TCE_QUEUE_DEPTH = 4;
	localparam int          JOB_BYTES = 5;

	typedef enum logic [2:0] {
		MODE_CS_START = 3'd0,
		MODE_INT      = 3'd1,
		MODE_CMD      = 3'd2,
		MODE_EX_START = 3'd3,
		MODE_EX_BYTE  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] number;
		logic [7:0]         first_code;
		logic [7:0]         second_code;
		logic               has_second;
		logic [7:0]         data_byte;
	} tok_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       from_eexec;
		logic       last_byte;
	} enc_t;

	// plain bytes leave from the top of pbytes; only the first cnt bytes are sent
	typedef struct packed {
		logic                     eex;
		logic                     reload;
		logic [3:0]               cnt;
		logic [JOB_BYTES*8-1:0]   pbytes;
	} job_t;

endpackage

`default_nettype wire

// ===== hdl/tce_front.sv =====
`default_nettype none

module tce_front
	import tce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tok_valid,
	output logic       tok_stall,
	input  tok_t       tok,
	input  logic [3:0] len_iv,
	output logic       push_valid,
	input  logic       push_ready,
	output job_t       push_job
);

	logic        vld_s1;
	job_t        job_s1;
	job_t        job;
	logic        job_ok;
	logic        accept;
	logic        neg;
	logic [31:0] num_u;
	logic [31:0] mag;
	logic [10:0] x;
	logic [7:0]  hi_byte;
	logic [7:0]  one_byte;

	assign num_u    = tok.number;
	assign neg      = num_u[31];
	assign mag      = neg ? (32'd0 - num_u) : num_u;
	assign x        = mag[10:0] - 11'd108;
	assign hi_byte  = {6'd0, x[9:8]} + (neg ? 8'd251 : 8'd247);
	assign one_byte = neg ? (8'd139 - mag[7:0]) : (8'd139 + mag[7:0]);

	always_comb begin
		job    = '0;
		job_ok = 1'b1;
		unique case (tok.mode)
			MODE_CS_START: begin
				job.reload = 1'b1;
				job.cnt    = len_iv;
			end
			MODE_INT: begin
				if (mag <= 32'd107) begin
					job.cnt    = 4'd1;
					job.pbytes = {one_byte, 32'd0};
				end else if (mag <= 32'd1131) begin
					job.cnt    = 4'd2;
					job.pbytes = {hi_byte, x[7:0], 24'd0};
				end else begin
					job.cnt    = 4'd5;
					job.pbytes = {8'hFF, num_u};
				end
			end
			MODE_CMD: begin
				job.cnt    = tok.has_second ? 4'd2 : 4'd1;
				job.pbytes = {tok.first_code, tok.second_code, 24'd0};
			end
			MODE_EX_START: begin
				job.eex    = 1'b1;
				job.reload = 1'b1;
				job.cnt    = EX_LEAD_LEN;
			end
			MODE_EX_BYTE: begin
				job.eex    = 1'b1;
				job.cnt    = 4'd1;
				job.pbytes = {tok.data_byte, 32'd0};
			end
			default: begin
				job_ok = 1'b0;
			end
		endcase
	end

	assign tok_stall  = vld_s1 & ~push_ready;
	assign accept     = tok_valid & ~tok_stall;
	assign push_valid = vld_s1;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= job_ok;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tce_fifo.sv =====
`default_nettype none

module tce_fifo
	import tce_pkg::*;
#(
	parameter int DEPTH = TCE_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tce_back.sv =====
`default_nettype none

module tce_back
	import tce_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  job_t pop_job,
	output logic enc_valid,
	input  logic enc_stall,
	output enc_t enc
);

	logic [JOB_BYTES*8-1:0] sh_q;
	logic [3:0]             rem_q;
	logic                   eex_q;
	logic [15:0]            cs_key_q;
	logic [15:0]            ex_key_q;
	logic                   enc_valid_q;
	enc_t                   enc_q;
	logic                   busy;
	logic                   emit;
	logic                   pop;
	logic                   last;
	logic [15:0]            key;
	logic [7:0]             c;
	logic [15:0]            sum;
	logic [15:0]            key_nxt;

	assign busy = rem_q != 4'd0;
	assign last = rem_q == 4'd1;
	assign emit = busy & (~enc_valid_q | ~enc_stall);
	assign pop_ready = ~busy | (emit & last);
	assign pop  = pop_valid & pop_ready;

	// one cipher round per cycle while busy and the output is not stalled
	assign key     = eex_q ? ex_key_q : cs_key_q;
	assign c       = sh_q[JOB_BYTES*8-1 -: 8] ^ key[15:8];
	assign sum     = {8'd0, c} + key;
	assign key_nxt = 16'(sum * CIPHER_MUL) + CIPHER_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= 4'd0;
			cs_key_q    <= CS_KEY_INIT;
			ex_key_q    <= EX_KEY_INIT;
			enc_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= pop_job.cnt;
			end else if (emit) begin
				rem_q <= rem_q - 4'd1;
			end
			// a reload from the next item overrides the last round of the current one
			if (pop && pop_job.reload && !pop_job.eex) begin
				cs_key_q <= CS_KEY_INIT;
			end else if (emit && !eex_q) begin
				cs_key_q <= key_nxt;
			end
			if (pop && pop_job.reload && pop_job.eex) begin
				ex_key_q <= EX_KEY_INIT;
			end else if (emit && eex_q) begin
				ex_key_q <= key_nxt;
			end
			if (emit) begin
				enc_valid_q <= 1'b1;
			end else if (!enc_stall) begin
				enc_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q  <= pop_job.pbytes;
			eex_q <= pop_job.eex;
		end else if (emit) begin
			sh_q <= {sh_q[JOB_BYTES*8-9:0], 8'd0};
		end
		if (emit) begin
			enc_q.cipher_byte <= c;
			enc_q.from_eexec  <= eex_q;
			enc_q.last_byte   <= last;
		end
	end

	assign enc_valid = enc_valid_q;
	assign enc       = enc_q;

endmodule

`default_nettype wire

// ===== hdl/type1_charstring_encrypt_encoder.sv =====
// channel | handshake            | payload
// tok     | tok_valid, tok_stall  | tok (tok_t): one token or eexec byte
// enc     | enc_valid, enc_stall  | enc (enc_t): one cipher byte
// cfg     | cfg_valid, cfg_ready  | cfg_data: len_iv, cfg_ready always high
//
// one cipher byte per cycle from the back end key loop while enc_stall is low; an item
// gives 1, 2 or 5 bytes for numbers, 1 or 2 for commands, len_iv or 4 for starts
// a taken item passes the front stage, the queue and the back end before its first byte reaches the output
// reset: charstring key 4330, eexec key 55665, len_iv 4, queue and output empty
// enc_stall holds the output register; the back end and then the queue back up,
// and tok_stall rises only once the queue is full and the front stage holds an item
`default_nettype none

module type1_charstring_encrypt_encoder
	import tce_pkg::*;
#(
	parameter int QUEUE_DEPTH = TCE_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tok_valid,
	output logic       tok_stall,
	input  tok_t       tok,
	output logic       enc_valid,
	input  logic       enc_stall,
	output enc_t       enc,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	logic [3:0] len_iv_q;
	logic       push_valid;
	logic       push_ready;
	job_t       push_job;
	logic       pop_valid;
	logic       pop_ready;
	job_t       pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_iv_q <= LEN_IV_INIT;
		end else if (cfg_valid && cfg_ready) begin
			len_iv_q <= cfg_data;
		end
	end

	tce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok        (tok),
		.len_iv     (len_iv_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	tce_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	tce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc       (enc)
	);

endmodule

`default_nettype wire

// ===== hdl/tce_checker.sv =====
`default_nettype none
`include "type1_charstring_encrypt_encoder_macros.svh"

module tce_checker
	import tce_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic enc_valid,
	input logic enc_stall,
	input enc_t enc
);

	logic [3:0] run_q;
	logic       eex_q;
	logic       take;

	assign take = enc_valid & ~enc_stall;

	// bytes already taken from the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 4'd0;
			eex_q <= 1'b0;
		end else if (take) begin
			run_q <= enc.last_byte ? 4'd0 : run_q + 4'd1;
			eex_q <= enc.from_eexec;
		end
	end

	`TCE_ASSERT_NEXT(a_enc_hold, enc_valid && enc_stall, enc_valid)
	`TCE_ASSERT_NEXT(a_enc_stable, enc_valid && enc_stall, $stable(enc))
	`TCE_ASSERT_NOW(a_same_cipher, take && (run_q != 4'd0), enc.from_eexec == eex_q)
	`TCE_ASSERT_NOW(a_eexec_len, take && enc.from_eexec, run_q <= 4'd3)

endmodule

bind type1_charstring_encrypt_encoder tce_checker u_chk (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import tce_pkg::*;

	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
	localparam logic [7:0] NUM_BIAS      = 8'd139;
	localparam logic [7:0] NUM_POS_LEAD  = 8'd247;
	localparam logic [7:0] NUM_NEG_LEAD  = 8'd251;
	localparam logic [7:0] NUM_WIDE_LEAD = 8'd255;
	localparam int         NUM_SHORT_MAX = 107;
	localparam int         NUM_MID_MAX   = 1131;
	localparam int         HOLD_CYCLES   = 200;
	localparam int         SETTLE_CYCLES = 12;

	logic       clk;
	logic       arst_n;
	logic       tok_valid;
	logic       tok_stall;
	tok_t       tok;
	logic       enc_valid;
	logic       enc_stall;
	enc_t       enc;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_data;

	logic [15:0] cs_key;
	logic [15:0] ex_key;
	logic [3:0]  lead_len;
	enc_t        expected_bytes[$];
	int          fail_count;
	logic        steady;
	logic        hold_go;
	int          hold_left;

	type1_charstring_encrypt_encoder DUT (
		.clk,
		.arst_n,
		.tok_valid,
		.tok_stall,
		.tok,
		.enc_valid,
		.enc_stall,
		.enc,
		.cfg_valid,
		.cfg_ready,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("type1_charstring_encrypt_encoder regression: fail");
		$finish;
	end

	function automatic logic [15:0] next_key(input logic [15:0] key, input logic [7:0] c);
		logic [31:0] acc;
		acc = (32'(c) + 32'(key)) * 32'(CIPHER_MUL) + 32'(CIPHER_ADD);
		return acc[15:0];
	endfunction

	// expected cipher bytes for one accepted item
	function automatic void predict_token(input tok_t t);
		logic [7:0]  plain[$];
		logic [31:0] mag;
		logic [31:0] x;
		logic        neg;
		logic        eex;
		logic [7:0]  c;
		enc_t        r;
		eex = 1'b0;
		case (t.mode)
			MODE_CS_START: begin
				cs_key = CS_KEY_INIT;
				for (int i = 0; i < lead_len; i++)
					plain.push_back(8'h00);
			end
			MODE_INT: begin
				neg = t.number[31];
				mag = neg ? (~t.number + 1'b1) : t.number;
				if (mag <= NUM_SHORT_MAX) begin
					plain.push_back(neg ? NUM_BIAS - mag[7:0] : NUM_BIAS + mag[7:0]);
				end else if (mag <= NUM_MID_MAX) begin
					x = mag - (NUM_SHORT_MAX + 1);
					plain.push_back(x[15:8] + (neg ? NUM_NEG_LEAD : NUM_POS_LEAD));
					plain.push_back(x[7:0]);
				end else begin
					plain.push_back(NUM_WIDE_LEAD);
					plain.push_back(t.number[31:24]);
					plain.push_back(t.number[23:16]);
					plain.push_back(t.number[15:8]);
					plain.push_back(t.number[7:0]);
				end
			end
			MODE_CMD: begin
				plain.push_back(t.first_code);
				if (t.has_second)
					plain.push_back(t.second_code);
			end
			MODE_EX_START: begin
				eex = 1'b1;
				ex_key = EX_KEY_INIT;
				for (int i = 0; i < EX_LEAD_LEN; i++)
					plain.push_back(8'h00);
			end
			MODE_EX_BYTE: begin
				eex = 1'b1;
				plain.push_back(t.data_byte);
			end
			default: ;
		endcase
		foreach (plain[i]) begin
			if (eex) begin
				c = plain[i] ^ ex_key[15:8];
				ex_key = next_key(ex_key, c);
			end else begin
				c = plain[i] ^ cs_key[15:8];
				cs_key = next_key(cs_key, c);
			end
			r.cipher_byte = c;
			r.from_eexec = eex;
			r.last_byte = (i == plain.size() - 1);
			expected_bytes.push_back(r);
		end
	endfunction

	function automatic tok_t make_token(input logic [2:0] m, input logic [31:0] num,
			input logic [7:0] first, input logic [7:0] second, input logic has2,
			input logic [7:0] data);
		tok_t t;
		t.mode = m;
		t.number = num;
		t.first_code = first;
		t.second_code = second;
		t.has_second = has2;
		t.data_byte = data;
		return t;
	endfunction

	function automatic tok_t random_token();
		tok_t t;
		int   pick;
		t = make_token(3'($urandom_range(MODE_SPARE_LAST)), $urandom, 8'($urandom),
			8'($urandom), 1'($urandom), 8'($urandom));
		pick = $urandom_range(99);
		if (pick < 6)
			t.mode = MODE_CS_START;
		else if (pick < 11)
			t.mode = MODE_EX_START;
		else if (pick < 50)
			t.mode = MODE_INT;
		else if (pick < 72)
			t.mode = MODE_CMD;
		else if (pick < 93)
			t.mode = MODE_EX_BYTE;
		else
			t.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
		case ($urandom_range(3))
			0: t.number = $urandom_range(2 * NUM_SHORT_MAX) - NUM_SHORT_MAX;
			1: t.number = $urandom_range(NUM_SHORT_MAX + 1, NUM_MID_MAX);
			2: t.number = -$urandom_range(NUM_SHORT_MAX + 1, NUM_MID_MAX);
			default: ;
		endcase
		return t;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// result side: random stall, long hold on request, check each byte
	always @(posedge clk) begin
		if (arst_n && enc_valid && !enc_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("cipher_byte expected none actual %0h", enc.cipher_byte);
				fail_count++;
			end else begin
				compare_field("cipher_byte", expected_bytes[0].cipher_byte, enc.cipher_byte);
				compare_field("from_eexec", 8'(expected_bytes[0].from_eexec), 8'(enc.from_eexec));
				compare_field("last_byte", 8'(expected_bytes[0].last_byte), 8'(enc.last_byte));
				void'(expected_bytes.pop_front());
			end
		end
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		enc_stall <= hold_go || hold_left > 1 || (!steady && $urandom_range(99) < 32);
	end

	task automatic send_token(input tok_t t);
		if (!steady && $urandom_range(99) < 32) begin
			tok_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		tok <= t;
		tok_valid <= 1'b1;
		do @(posedge clk); while (tok_stall);
		predict_token(t);
	endtask

	task automatic settle();
		tok_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len_iv(input logic [3:0] v);
		settle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lead_len = v;
	endtask

	task automatic test_keys_without_start();
		send_token(make_token(MODE_INT, 32'd0, 8'h00, 8'h00, 1'b0, 8'h00));
		send_token(make_token(MODE_EX_BYTE, 32'd0, 8'h00, 8'h00, 1'b0, 8'h00));
		send_token(make_token(MODE_CMD, 32'd0, 8'h15, 8'h00, 1'b0, 8'h00));
	endtask

	task automatic test_number_formats();
		logic [31:0] nums[10];
		nums = '{107, -107, 108, -108, 1131, -1131, 1132, -1132,
			32'h7fffffff, 32'h80000000};
		send_token(make_token(MODE_CS_START, 32'd0, 8'h00, 8'h00, 1'b0, 8'h00));
		foreach (nums[i])
			send_token(make_token(MODE_INT, nums[i], 8'hff, 8'hff, 1'b1, 8'hff));
	endtask

	task automatic test_commands();
		send_token(make_token(MODE_CMD, 32'hffffffff, 8'hff, 8'hff, 1'b0, 8'hff));
		send_token(make_token(MODE_CMD, 32'd0, 8'h0c, 8'h00, 1'b1, 8'h00));
		send_token(make_token(MODE_CMD, 32'd0, 8'h00, 8'hff, 1'b1, 8'h00));
	endtask

	task automatic test_eexec();
		send_token(make_token(MODE_EX_START, 32'd0, 8'h00, 8'h00, 1'b0, 8'hff));
		send_token(make_token(MODE_EX_BYTE, 32'hffffffff, 8'hff, 8'hff, 1'b1, 8'hff));
		send_token(make_token(MODE_EX_BYTE, 32'd0, 8'h00, 8'h00, 1'b0, 8'h00));
	endtask

	task automatic test_unused_modes();
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			send_token(make_token(3'(m), $urandom, 8'($urandom), 8'($urandom),
				1'($urandom), 8'($urandom)));
		send_token(make_token(MODE_INT, 32'd1, 8'h00, 8'h00, 1'b0, 8'h00));
	endtask

	task automatic test_lead_length();
		write_len_iv(4'd0);
		send_token(make_token(MODE_CS_START, 32'd0, 8'h00, 8'h00, 1'b0, 8'h00));
		send_token(make_token(MODE_INT, 32'd5, 8'h00, 8'h00, 1'b0, 8'h00));
		write_len_iv(4'd15);
		send_token(make_token(MODE_CS_START, 32'd0, 8'h00, 8'h00, 1'b0, 8'h00));
		write_len_iv(LEN_IV_INIT);
	endtask

	task automatic test_output_hold();
		tok_valid <= 1'b0;
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (24) send_token(random_token());
	endtask

	task automatic test_sender_pause();
		repeat (6) send_token(random_token());
		settle();
		repeat (6) send_token(random_token());
	endtask

	task automatic test_random_traffic();
		logic [3:0] lengths[5];
		lengths = '{4'd0, 4'd15, 4'($urandom), 4'd1, 4'($urandom)};
		foreach (lengths[p]) begin
			write_len_iv(lengths[p]);
			steady <= (p == 2);
			repeat (40) send_token(random_token());
		end
		steady <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		tok_valid = 1'b0;
		tok = '0;
		enc_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		hold_go = 1'b0;
		hold_left = 0;
		fail_count = 0;
		cs_key = CS_KEY_INIT;
		ex_key = EX_KEY_INIT;
		lead_len = LEN_IV_INIT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keys_without_start();
		test_number_formats();
		test_commands();
		test_eexec();
		test_unused_modes();
		test_lead_length();
		test_output_hold();
		test_sender_pause();
		test_random_traffic();
		settle();
		if (fail_count == 0)
			$display("type1_charstring_encrypt_encoder regression: pass");
		else
			$display("type1_charstring_encrypt_encoder regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tce_pkg.sv
hdl/tce_front.sv
hdl/tce_fifo.sv
hdl/tce_back.sv
hdl/type1_charstring_encrypt_encoder.sv
hdl/tce_checker.sv
test/tb_top.sv
